// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the encoder checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define UUB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define UUB_ASSERT_NEXT(label, clk, ante, cons, rst, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define UUB_ASSERT_RESET(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/uub64_pkg.sv =====
// ---------------------------------------------------------------------------
// uub64_pkg
// Types, constants and character mapping functions of the line encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package uub64_pkg;

  // Line geometry: a full line holds LINE_FULL bytes, a multiple of three.
  localparam int LINE_SIZE  = 45;
  localparam int LINE_FULL  = ((LINE_SIZE + 2) / 3) * 3;
  localparam int IDX_W      = $clog2(LINE_FULL + 1);

  // Line store: two banks, addressed as {bank, index}.
  localparam int RAM_AW    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;
  localparam int BYTE_W    = 8;

  // Number of lines that may wait for or be in the back end at once.
  localparam int LINES_MAX = 2;
  localparam int BUSY_W    = $clog2(LINES_MAX + 1);

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Characters.
  localparam int CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CH_NL   = 7'd10;
  localparam logic [CHAR_W-1:0] CH_PAD  = 7'd61;
  localparam logic [CHAR_W-1:0] CH_TICK = 7'd96;

  // Encoding modes.
  localparam logic MODE_TRAD = 1'b0;
  localparam logic MODE_B64  = 1'b1;

  // One unit of work for the back end.
  typedef struct packed {
    logic             line;      // a line is to be emitted
    logic             end_flag;  // the stream ends after this command
    logic             bank;      // line store bank that holds the line
    logic [IDX_W-1:0] count;     // bytes in the line
  } cmd_t;

  // Traditional table: zero maps to a backtick, anything else to 32 + v.
  function automatic logic [CHAR_W-1:0] trad_char(input logic [5:0] v);
    logic [CHAR_W-1:0] c;
    if (v == 6'd0) begin
      c = CH_TICK;
    end else begin
      c = 7'd32 + {1'b0, v};
    end
    return c;
  endfunction

  // Base64 alphabet, computed by range.
  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
    logic [CHAR_W-1:0] c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      c = 7'd43;
    end else begin
      c = 7'd47;
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] sym_char(input logic mode, input logic [5:0] v);
    return (mode == MODE_B64) ? b64_char(v) : trad_char(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/uub64_ifs.sv =====
// ---------------------------------------------------------------------------
// Encoder channel interfaces
// Valid/ready channels for raw bytes, encoded characters and configuration.
// ---------------------------------------------------------------------------
`default_nettype none

// Raw byte channel.
interface uub64_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_data;

  modport source (output valid, data_byte, has_byte, end_of_data, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_data, output ready);
endinterface

// Encoded character channel.
interface uub64_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_of_run;

  modport source (output valid, out_char, last_of_run, input ready);
  modport sink (input valid, out_char, last_of_run, output ready);
endinterface

// Configuration write channel.
interface uub64_cfg_if;
  logic valid;
  logic ready;
  logic encoding_mode;

  modport source (output valid, encoding_mode, input ready);
  modport sink (input valid, encoding_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/uub64_ram.sv =====
// ---------------------------------------------------------------------------
// uub64_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module uub64_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/uub64_queue.sv =====
// ---------------------------------------------------------------------------
// uub64_queue
// Short command queue between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module uub64_queue
  import uub64_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output      logic push_ready,
  input  wire cmd_t push_data,
  output      logic pop_valid,
  input  wire logic pop_ready,
  output      cmd_t pop_data
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uub64_front.sv =====
// ---------------------------------------------------------------------------
// uub64_front
// Accepts raw bytes, fills the line store and issues line commands.
// ---------------------------------------------------------------------------
`default_nettype none

module uub64_front
  import uub64_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  uub64_byte_if.sink             byte_ch,
  // Line store write port.
  output      logic              ram_we,
  output      logic [RAM_AW-1:0] ram_waddr,
  output      logic [BYTE_W-1:0] ram_wdata,
  // Command queue push side.
  output      logic              push_valid,
  input  wire logic              push_ready,
  output      cmd_t              push_data,
  // Back end has finished reading a line.
  input  wire logic              line_done
);

  logic [IDX_W-1:0]  count;
  logic [IDX_W-1:0]  count_next;
  logic [IDX_W-1:0]  count_after;
  logic              bank;
  logic [BUSY_W-1:0] busy;
  logic              accept;
  logic              full;
  logic              line;

  // The bank being filled is free unless both banks hold pending lines.
  assign byte_ch.ready = push_ready && (busy != BUSY_W'(LINES_MAX));
  assign accept        = byte_ch.valid && byte_ch.ready;

  // Classify the beat.
  assign count_after = count + IDX_W'(byte_ch.has_byte);
  assign full        = byte_ch.has_byte && (count_after == IDX_W'(LINE_FULL));
  assign line        = full || (byte_ch.end_of_data && (count_after != '0));
  assign count_next  = line ? '0 : count_after;

  // Store the byte at the next free place of the current bank.
  assign ram_we    = accept && byte_ch.has_byte;
  assign ram_waddr = {bank, count};
  assign ram_wdata = byte_ch.data_byte;

  // Command for the back end.
  assign push_valid         = accept && (line || byte_ch.end_of_data);
  assign push_data.line     = line;
  assign push_data.end_flag = byte_ch.end_of_data;
  assign push_data.bank     = bank;
  assign push_data.count    = count_after;

  // Fill count, bank select and pending line count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      bank  <= 1'b0;
      busy  <= '0;
    end else begin
      if (accept) begin
        count <= count_next;
        if (line) begin
          bank <= ~bank;
        end
      end
      busy <= busy + BUSY_W'(accept && line) - BUSY_W'(line_done);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uub64_back.sv =====
// ---------------------------------------------------------------------------
// uub64_back
// Sequencer that reads a line from the store and emits its characters.
// ---------------------------------------------------------------------------
`default_nettype none

module uub64_back
  import uub64_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              mode,
  // Command queue pop side.
  input  wire logic              pop_valid,
  output      logic              pop_ready,
  input  wire cmd_t              pop_data,
  // Line store read port.
  output      logic [RAM_AW-1:0] ram_raddr,
  input  wire logic [BYTE_W-1:0] ram_rdata,
  // Character output.
  uub64_char_if.source           char_ch,
  output      logic              line_done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_FETCH,
    ST_SYM,
    ST_NL,
    ST_TICK,
    ST_TNL
  } state_t;

  state_t            state;
  cmd_t              cmd;
  logic [IDX_W-1:0]  grp;
  logic [1:0]        fetch;
  logic [1:0]        sym;
  logic [BYTE_W-1:0] b0;
  logic [BYTE_W-1:0] b1;
  logic [BYTE_W-1:0] b2;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              can_emit;
  logic              emit;
  logic              trailer;
  logic [IDX_W:0]    cap_idx;
  logic              cap_ok;
  logic [IDX_W:0]    grp_plus;
  logic [5:0]        sym_val;
  logic [CHAR_W-1:0] sym_out;

  assign char_ch.valid       = out_valid;
  assign char_ch.out_char    = out_char;
  assign char_ch.last_of_run = out_last;

  assign can_emit  = !out_valid || char_ch.ready;
  assign pop_ready = (state == ST_IDLE);
  assign trailer   = cmd.end_flag && (mode == MODE_TRAD);
  assign line_done = (state == ST_NL) && can_emit;

  // A character is loaded into the output register this cycle.
  assign emit = can_emit && ((state == ST_LEN) || (state == ST_SYM) || (state == ST_NL) ||
                             (state == ST_TICK) || (state == ST_TNL));

  // Read address of the current fetch step; data returns in the next cycle.
  assign ram_raddr = {cmd.bank, grp + IDX_W'(fetch)};
  assign cap_idx   = {1'b0, grp} + (IDX_W + 1)'(fetch) - (IDX_W + 1)'(1);
  assign cap_ok    = cap_idx < {1'b0, cmd.count};
  assign grp_plus  = {1'b0, grp} + (IDX_W + 1)'(3);

  // Symbol of the current group, with Base64 padding past the line end.
  always_comb begin
    case (sym)
      2'd0:    sym_val = b0[7:2];
      2'd1:    sym_val = {b0[1:0], b1[7:4]};
      2'd2:    sym_val = {b1[3:0], b2[7:6]};
      default: sym_val = b2[5:0];
    endcase
    sym_out = sym_char(mode, sym_val);
    if (mode == MODE_B64) begin
      if ((sym == 2'd2) && (({1'b0, grp} + (IDX_W + 1)'(1)) >= {1'b0, cmd.count})) begin
        sym_out = CH_PAD;
      end
      if ((sym == 2'd3) && (({1'b0, grp} + (IDX_W + 1)'(2)) >= {1'b0, cmd.count})) begin
        sym_out = CH_PAD;
      end
    end
  end

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (char_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            cmd   <= pop_data;
            grp   <= '0;
            fetch <= '0;
            if (pop_data.line) begin
              state <= (mode == MODE_TRAD) ? ST_LEN : ST_FETCH;
            end else if (pop_data.end_flag && (mode == MODE_TRAD)) begin
              state <= ST_TICK;
            end
          end
        end
        ST_LEN: begin
          if (can_emit) begin
            out_char  <= trad_char(6'(cmd.count));
            out_last  <= 1'b0;
            state     <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          // Three reads, shifted in as they return; bytes past the count are zero.
          fetch <= fetch + 2'd1;
          if (fetch != 2'd0) begin
            b0 <= b1;
            b1 <= b2;
            b2 <= cap_ok ? ram_rdata : '0;
          end
          if (fetch == 2'd3) begin
            sym   <= 2'd0;
            state <= ST_SYM;
          end
        end
        ST_SYM: begin
          if (can_emit) begin
            out_char  <= sym_out;
            out_last  <= 1'b0;
            sym       <= sym + 2'd1;
            if (sym == 2'd3) begin
              grp   <= grp_plus[IDX_W-1:0];
              fetch <= '0;
              state <= (grp_plus >= {1'b0, cmd.count}) ? ST_NL : ST_FETCH;
            end
          end
        end
        ST_NL: begin
          if (can_emit) begin
            out_char  <= CH_NL;
            out_last  <= !trailer;
            state     <= trailer ? ST_TICK : ST_IDLE;
          end
        end
        ST_TICK: begin
          if (can_emit) begin
            out_char  <= CH_TICK;
            out_last  <= 1'b0;
            state     <= ST_TNL;
          end
        end
        ST_TNL: begin
          if (can_emit) begin
            out_char  <= CH_NL;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uuencode_base64_line_encoder.sv =====
// ---------------------------------------------------------------------------
// uuencode_base64_line_encoder
// Line-oriented uuencode / Base64 encoder, one character per output beat.
// ---------------------------------------------------------------------------
// Raw bytes are gathered into lines of 45 in a two-bank line store; each full
// line, and the short tail at end of data, is emitted as groups of four
// characters followed by a newline; in traditional mode a length character
// goes in front and a closing "`" line follows the stream. A byte beat is
// normally taken as soon as it is offered; it stalls only while both store
// banks hold lines still waiting to be emitted or the two-entry command queue
// is full. Emission is set by the back end sequencer: each group of three
// bytes is first read from the store and shifted in, and then sent as four
// character beats. The mode register is sampled when a line is emitted and
// should be written only while no data is in flight.
`default_nettype none

module uuencode_base64_line_encoder
  import uub64_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  uub64_byte_if.sink    byte_ch,
  uub64_char_if.source  char_ch,
  uub64_cfg_if.sink     cfg
);

  logic              mode;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              push_valid;
  logic              push_ready;
  cmd_t              push_data;
  logic              pop_valid;
  logic              pop_ready;
  cmd_t              pop_data;
  logic              line_done;

  // Mode register; a write beat is always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TRAD;
    end else if (cfg.valid) begin
      mode <= cfg.encoding_mode;
    end
  end

  uub64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .line_done  (line_done)
  );

  uub64_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  uub64_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  uub64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .char_ch    (char_ch),
    .line_done  (line_done)
  );

endmodule

`default_nettype wire

// ===== rtl/uub64_checker.sv =====
// ---------------------------------------------------------------------------
// uub64_checker
// Port-level checks of the encoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module uub64_checker
  import uub64_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CHAR_W-1:0] out_char,
  input wire logic              out_last
);

  // A stalled character beat holds.
  `UUB_ASSERT_NEXT(a_out_hold, clk, out_valid && !out_ready,
                   out_valid && $stable(out_char) && $stable(out_last), rst,
                   "stalled output beat changed")

  // Every run of characters closes with a newline.
  `UUB_ASSERT_NOW(a_last_is_nl, clk, rst, out_valid && out_last, out_char == CH_NL,
                  "run does not end in a newline")

  // Output is printable text or a newline.
  `UUB_ASSERT_NOW(a_printable, clk, rst, out_valid,
                  (out_char == CH_NL) || (out_char >= 7'd32),
                  "output character is not printable")

  // Reset empties the output register.
  `UUB_ASSERT_RESET(a_reset_idle, clk, rst, !out_valid,
                    "output valid after reset")

endmodule

bind uuencode_base64_line_encoder uub64_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (char_ch.valid),
  .out_ready (char_ch.ready),
  .out_char  (char_ch.out_char),
  .out_last  (char_ch.last_of_run)
);

`default_nettype wire

// ===== tb/uuencode_base64_line_encoder_tb.sv =====
// ---------------------------------------------------------------------------
// uuencode_base64_line_encoder_tb
// Self-checking bench for the line encoder. The bench sends byte beats in
// both encoding modes and predicts every encoded character, including the
// length prefix, the padding and the closing line. Each character beat is
// checked against the oldest expected one. The byte source idles in bursts,
// the character sink stalls on its own pattern, and one long sink hold-off
// fills the block until it stalls its input.
// ---------------------------------------------------------------------------

module uuencode_base64_line_encoder_tb;
  import uub64_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RANDOM_ITEMS   = 60;
  localparam int SHORT_STREAMS  = 6;
  localparam int HOLD_CYCLES    = 700;
  localparam int REPORT_MAX     = 40;

  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } enc_char_t;

  logic clk;
  logic rst;

  uub64_byte_if byte_ch ();
  uub64_char_if char_ch ();
  uub64_cfg_if  cfg_ch ();

  uuencode_base64_line_encoder u_top (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .char_ch (char_ch),
    .cfg     (cfg_ch)
  );

  // Encoder state as the bench sees it.
  logic [7:0] line_buf [LINE_FULL];
  int         line_fill = 0;
  logic       mode_copy = MODE_TRAD;

  // Characters owed by the block, oldest first, and the run being built.
  enc_char_t expected_chars [$];
  enc_char_t run_chars [$];

  int err_count    = 0;
  int idle_cycles  = 0;
  int rx_stall_max = 0;
  int hold_seq     = 0;
  bit sender_gaps  = 1'b1;
  int burst_left   = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Traditional table image of a six-bit symbol.
  function automatic logic [CHAR_W-1:0] uu_symbol(input logic [5:0] v);
    return (v == 6'd0) ? CH_TICK : 7'd32 + {1'b0, v};
  endfunction

  // Symbol image in the given mode.
  function automatic logic [CHAR_W-1:0] symbol_char(input logic m, input logic [5:0] v);
    if (m == MODE_B64) begin
      return B64_ALPHABET[8*(63 - int'(v)) +: 7];
    end
    return uu_symbol(v);
  endfunction

  task automatic add_char(input logic [CHAR_W-1:0] c);
    run_chars.push_back('{ch: c, last: 1'b0});
  endtask

  // Encodes the first count bytes of the line buffer as one output line.
  task automatic encode_line(input int count);
    logic [7:0] b0, b1, b2;
    logic [5:0] s0, s1, s2, s3;
    if (mode_copy == MODE_TRAD) begin
      add_char(uu_symbol(6'(count)));
    end
    for (int g = 0; g < count; g += 3) begin
      b0 = line_buf[g];
      b1 = (g + 1 < count) ? line_buf[g+1] : 8'd0;
      b2 = (g + 2 < count) ? line_buf[g+2] : 8'd0;
      s0 = b0[7:2];
      s1 = {b0[1:0], b1[7:4]};
      s2 = {b1[3:0], b2[7:6]};
      s3 = b2[5:0];
      add_char(symbol_char(mode_copy, s0));
      add_char(symbol_char(mode_copy, s1));
      if (mode_copy == MODE_B64 && g + 1 >= count) begin
        add_char(CH_PAD);
      end else begin
        add_char(symbol_char(mode_copy, s2));
      end
      if (mode_copy == MODE_B64 && g + 2 >= count) begin
        add_char(CH_PAD);
      end else begin
        add_char(symbol_char(mode_copy, s3));
      end
    end
    add_char(CH_NL);
  endtask

  // Works out the characters that one accepted byte beat causes.
  task automatic predict_beat(input logic [7:0] d, input logic h, input logic e);
    enc_char_t item;
    run_chars.delete();
    if (h) begin
      if (line_fill < LINE_FULL) begin
        line_buf[line_fill] = d;
        line_fill++;
      end
      if (line_fill >= LINE_FULL) begin
        encode_line(line_fill);
        line_fill = 0;
      end
    end
    if (e) begin
      if (line_fill > 0) begin
        encode_line(line_fill);
        line_fill = 0;
      end
      if (mode_copy == MODE_TRAD) begin
        add_char(CH_TICK);
        add_char(CH_NL);
      end
    end
    foreach (run_chars[i]) begin
      item = run_chars[i];
      item.last = (i == run_chars.size() - 1);
      expected_chars.push_back(item);
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= REPORT_MAX) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // Beat monitor: the byte beat is predicted before the character beat of the
  // same edge is checked.
  always @(posedge clk) begin
    enc_char_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        mode_copy = cfg_ch.encoding_mode;
      end
      if (byte_ch.valid && byte_ch.ready) begin
        predict_beat(byte_ch.data_byte, byte_ch.has_byte, byte_ch.end_of_data);
      end
      if (char_ch.valid && char_ch.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                    char_ch.out_char, char_ch.last_of_run));
        end else begin
          want = expected_chars.pop_front();
          if (char_ch.out_char != want.ch) begin
            report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                      char_ch.out_char, want.ch));
          end
          if (char_ch.last_of_run != want.last) begin
            report_mismatch($sformatf("last_of_run %0b, expected %0b (char 0x%02h)",
                                      char_ch.last_of_run, want.last, want.ch));
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Character sink: random ready/stall phases, or a long hold-off on request.
  initial begin : char_sink
    int phase_left;
    bit rdy_phase;
    int hold_left;
    int hold_seen;
    char_ch.ready = 1'b0;
    phase_left    = 0;
    rdy_phase     = 1'b0;
    hold_left     = 0;
    hold_seen     = 0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        char_ch.ready <= 1'b0;
      end else if (rx_stall_max == 0) begin
        char_ch.ready <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          rdy_phase  = !rdy_phase;
          phase_left = rdy_phase ? $urandom_range(1, 16) : $urandom_range(1, rx_stall_max);
        end
        phase_left--;
        char_ch.ready <= rdy_phase;
      end
    end
  end

  // Offers one byte beat, waits for it to be taken, then idles between bursts.
  task automatic send_item(input logic [7:0] d, input logic h, input logic e);
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= d;
    byte_ch.has_byte    <= h;
    byte_ch.end_of_data <= e;
    do @(posedge clk); while (!byte_ch.ready);
    @(negedge clk);
    if (sender_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= 8'($urandom);
        byte_ch.has_byte    <= 1'($urandom_range(0, 1));
        byte_ch.end_of_data <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      end
    end
  endtask

  // Lets every owed character arrive and the back end go quiet.
  task automatic settle_idle();
    byte_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    settle_idle();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.encoding_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Idle beats and empty streams in both modes.
  task automatic test_idle_and_empty();
    write_mode(MODE_TRAD);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    write_mode(MODE_B64);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
  endtask

  // Tails of one, two and three bytes with extreme values in both modes.
  task automatic test_short_tails();
    logic m;
    for (int k = 0; k < 2; k++) begin
      m = (k == 0) ? MODE_TRAD : MODE_B64;
      write_mode(m);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'ha5, 1'b1, 1'b0);
      send_item(8'h5a, 1'b0, 1'b1);
    end
  endtask

  // Sink holds off while a full line and then a string of one-byte streams
  // are offered back to back, so both store banks fill and the block stalls
  // its input; the first stream ends on a full line.
  task automatic test_backpressure();
    write_mode(MODE_TRAD);
    sender_gaps = 1'b0;
    hold_seq++;
    for (int i = 0; i < LINE_FULL; i++) begin
      send_item(8'($urandom), 1'b1, (i == LINE_FULL - 1));
    end
    for (int i = 0; i < SHORT_STREAMS; i++) begin
      send_item(8'($urandom), 1'b1, 1'b1);
    end
    sender_gaps = 1'b1;
  endtask

  // Random streams of random length and content, with stray idle beats,
  // mode changes between streams and varying sink stalls.
  task automatic test_random_streams();
    int  taken;
    int  len;
    int  r;
    bit  end_on_byte;
    bit  first;
    taken = 0;
    first = 1'b1;
    while (taken < RANDOM_ITEMS) begin
      if (first) begin
        write_mode(MODE_B64);
      end else if ($urandom_range(0, 2) == 0) begin
        write_mode(1'($urandom_range(0, 1)));
      end
      case ($urandom_range(0, 3))
        0: rx_stall_max = 0;
        1: rx_stall_max = 2;
        2: rx_stall_max = 6;
        default: rx_stall_max = 20;
      endcase
      r = $urandom_range(0, 9);
      if (first || r == 5 || r == 6) begin
        len = LINE_FULL;
      end else if (r < 5) begin
        len = $urandom_range(0, 6);
      end else begin
        len = $urandom_range(7, LINE_FULL + 8);
      end
      first       = 1'b0;
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(8'($urandom), 1'b0, 1'b0);
        end
        send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte) begin
        send_item(8'($urandom), 1'b0, 1'b1);
        taken++;
      end
      taken += len;
    end
  endtask

  // Test sequence.
  initial begin
    rst                  = 1'b1;
    byte_ch.valid        = 1'b0;
    byte_ch.data_byte    = 8'd0;
    byte_ch.has_byte     = 1'b0;
    byte_ch.end_of_data  = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.encoding_mode = MODE_TRAD;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    rx_stall_max = 3;
    test_idle_and_empty();
    test_short_tails();
    test_backpressure();
    test_random_streams();

    settle_idle();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
